>>> src/dtb_pkg.sv
// Shared constants, codes and types of the deadline timer bank.
`timescale 1ns / 1ps

package dtb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_W     = 64;
  localparam int IDX_W      = 4;
  localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              fired_valid;
    logic [IDX_W-1:0]  fired_index;
    logic              armed;
    logic [TIME_W-1:0] earliest_deadline;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] data;
  } ram_wr_t;

endpackage

>>> src/dtb_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module dtb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/dtb_ctrl.sv
// Sequencer: applies set/cancel, scans the deadline RAM, walks the expiry mask.
`timescale 1ns / 1ps

module dtb_ctrl import dtb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [IDX_W-1:0]  in_timer_index,
  input  logic [TIME_W-1:0] in_deadline,
  input  logic [TIME_W-1:0] in_current_time,
  output ram_wr_t           ram_wr,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [TIME_W-1:0] ram_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  state_t                  state_r, state_nxt;
  logic [NUM_TIMERS-1:0]   valid_r, valid_nxt;
  logic [NUM_TIMERS-1:0]   mask_r, mask_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    proc_en_r, proc_en_nxt;
  logic [ADDR_W-1:0]       proc_idx_r, proc_idx_nxt;
  logic                    proc_vld_r, proc_vld_nxt;
  logic                    tick_r, tick_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [TIME_W-1:0]       min_r, min_nxt;
  logic                    any_r, any_nxt;
  logic                    fire_any_r, fire_any_nxt;
  logic [ADDR_W-1:0]       last_fire_r, last_fire_nxt;
  logic [ADDR_W-1:0]       emit_r, emit_nxt;

  logic [ADDR_W+IDX_W-1:0] idx_ext;
  logic [ADDR_W+IDX_W-1:0] fired_ext;
  logic                    in_range;
  logic [TIME_W-1:0]       dl;
  logic                    expire;

  assign idx_ext   = {{ADDR_W{1'b0}}, in_timer_index};
  assign fired_ext = {{IDX_W{1'b0}}, emit_r};
  assign in_range  = int'(in_timer_index) < NUM_TIMERS;
  // entries never written since reset read as inactive
  assign dl        = proc_vld_r ? ram_rdata : '0;
  assign expire    = proc_en_r && tick_r && (dl != '0) && (dl <= now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      proc_en_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      proc_en_r <= proc_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r      <= mask_nxt;
    cnt_r       <= cnt_nxt;
    proc_idx_r  <= proc_idx_nxt;
    proc_vld_r  <= proc_vld_nxt;
    tick_r      <= tick_nxt;
    now_r       <= now_nxt;
    min_r       <= min_nxt;
    any_r       <= any_nxt;
    fire_any_r  <= fire_any_nxt;
    last_fire_r <= last_fire_nxt;
    emit_r      <= emit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    proc_en_nxt   = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    proc_vld_nxt  = proc_vld_r;
    tick_nxt      = tick_r;
    now_nxt       = now_r;
    min_nxt       = min_r;
    any_nxt       = any_r;
    fire_any_nxt  = fire_any_r;
    last_fire_nxt = last_fire_r;
    emit_nxt      = emit_r;
    in_ready      = 1'b0;
    ram_wr.we     = 1'b0;
    ram_wr.addr   = idx_ext[ADDR_W-1:0];
    ram_wr.data   = (in_kind == KIND_SET) ? in_deadline : '0;
    ram_raddr     = cnt_r[ADDR_W-1:0];
    res_valid     = 1'b0;
    res.fired_valid       = fire_any_r;
    res.fired_index       = fire_any_r ? fired_ext[IDX_W-1:0] : '0;
    res.armed             = any_r;
    res.earliest_deadline = min_r;
    res.last              = !fire_any_r || (emit_r == last_fire_r);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((in_kind == KIND_SET || in_kind == KIND_CANCEL) && in_range) begin
            ram_wr.we = 1'b1;
            valid_nxt[idx_ext[ADDR_W-1:0]] = 1'b1;
          end
          tick_nxt     = (in_kind == KIND_TICK) && (in_current_time != '0);
          now_nxt      = in_current_time;
          min_nxt      = '0;
          any_nxt      = 1'b0;
          fire_any_nxt = 1'b0;
          mask_nxt     = '0;
          cnt_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read issue runs one entry ahead of the compare stage
        if (cnt_r < CNT_W'(NUM_TIMERS)) begin
          proc_en_nxt  = 1'b1;
          proc_idx_nxt = cnt_r[ADDR_W-1:0];
          proc_vld_nxt = valid_r[cnt_r[ADDR_W-1:0]];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT;
        end
        if (expire) begin
          valid_nxt[proc_idx_r] = 1'b0;
          mask_nxt[proc_idx_r]  = 1'b1;
          last_fire_nxt         = proc_idx_r;
          fire_any_nxt          = 1'b1;
        end else if (proc_en_r && (dl != '0) && (!any_r || dl < min_r)) begin
          min_nxt = dl;
          any_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!fire_any_r) begin
          res_valid = 1'b1;
          if (res_ready) begin
            state_nxt = ST_IDLE;
          end
        end else if (mask_r[emit_r]) begin
          res_valid = 1'b1;
          if (res_ready) begin
            if (emit_r == last_fire_r) begin
              state_nxt = ST_IDLE;
            end else begin
              emit_nxt = emit_r + ADDR_W'(1);
            end
          end
        end else begin
          emit_nxt = emit_r + ADDR_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !res_valid)
    else $error("result offered during scan");

  a_fire_bit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.fired_valid |-> mask_r[emit_r])
    else $error("fired result for a timer not in the expiry mask");

  a_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.fired_valid |-> mask_r == '0 && res.last)
    else $error("idle result while expiries are pending");

  a_armed: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.armed == (res.earliest_deadline != '0))
    else $error("armed flag disagrees with earliest deadline");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SCAN && cnt_r == '0)
    else $error("accepted item did not start a scan");

endmodule

>>> src/deadline_timer_bank.sv
// Top level of the deadline timer bank: RAM, sequencer and result register.
`timescale 1ns / 1ps

// Bank of NUM_TIMERS one-shot timers holding absolute deadlines in a single
// RAM with one read and one write port. Each item (set, cancel or tick) is
// accepted while idle, then every entry is scanned through the RAM read
// port, expiring timers and finding the earliest active deadline. Results
// then leave through a one-deep output register: a single result for an
// item with no expiry, otherwise one per expired timer, as the emit state
// steps through each timer index up to the highest expired one, stalling
// while the output register is full. The next item is accepted only once
// the output register takes the last result. Deadlines reset to inactive
// at once through per-entry valid flags, so no clearing pass is needed.
module deadline_timer_bank import dtb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [IDX_W-1:0]  in_timer_index,
  input  logic [TIME_W-1:0] in_deadline,
  input  logic [TIME_W-1:0] in_current_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fired_valid,
  output logic [IDX_W-1:0]  out_fired_index,
  output logic              out_armed,
  output logic [TIME_W-1:0] out_earliest_deadline,
  output logic              out_last
);

  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TIME_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;

  dtb_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (TIME_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dtb_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_timer_index  (in_timer_index),
    .in_deadline     (in_deadline),
    .in_current_time (in_current_time),
    .ram_wr          (ram_wr),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // output register takes a new item whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_fired_valid       = out_r.fired_valid;
  assign out_fired_index       = out_r.fired_index;
  assign out_armed             = out_r.armed;
  assign out_earliest_deadline = out_r.earliest_deadline;
  assign out_last              = out_r.last;

endmodule
